// ===== hw/rtl/tod_pkg.sv =====
package tod_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ENABLED   = 2'd0,
		CFG_POLL_MS   = 2'd1,
		CFG_STABLE_MS = 2'd2,
		CFG_TILT_TH   = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned ACCEL_W    = 16;
	localparam int unsigned TH_W       = 15;
	localparam int unsigned MAG_W      = ACCEL_W + 1;

	// Reset values of the configuration registers.
	localparam logic [15:0]     POLL_MS_RST   = 16'd100;
	localparam logic [15:0]     STABLE_MS_RST = 16'd300;
	localparam logic [TH_W-1:0] TILT_TH_RST   = 15'd4096;

	// Quarter-turn codes picked by the classifier.
	localparam logic [1:0] ROT_X_POS = 2'd0;
	localparam logic [1:0] ROT_Y_NEG = 2'd1;
	localparam logic [1:0] ROT_X_NEG = 2'd2;
	localparam logic [1:0] ROT_Y_POS = 2'd3;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic            enabled;
		logic [15:0]     poll_ms;
		logic [15:0]     stable_ms;
		logic [TH_W-1:0] tilt_th;
	} cfg_t;

	// Classifier verdict for one sample.
	typedef struct packed {
		logic       ambiguous;
		logic [1:0] rot;
	} class_t;

endpackage

// ===== hw/rtl/tod_classify.sv =====
module tod_classify (
	input  logic signed [tod_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [tod_pkg::ACCEL_W-1:0] accel_y,
	input  logic [tod_pkg::TH_W-1:0]           tilt_th,
	output tod_pkg::class_t                    verdict
);

	logic [tod_pkg::MAG_W-1:0] ext_x;
	logic [tod_pkg::MAG_W-1:0] ext_y;
	logic [tod_pkg::MAG_W-1:0] mag_x;
	logic [tod_pkg::MAG_W-1:0] mag_y;
	logic [tod_pkg::MAG_W-1:0] th_ext;
	logic                      x_pos;
	logic                      y_pos;

	// Magnitudes in one extra bit so that the most negative value still fits.
	assign ext_x  = {accel_x[tod_pkg::ACCEL_W-1], accel_x};
	assign ext_y  = {accel_y[tod_pkg::ACCEL_W-1], accel_y};
	assign mag_x  = accel_x[tod_pkg::ACCEL_W-1] ? (tod_pkg::MAG_W'(0) - ext_x) : ext_x;
	assign mag_y  = accel_y[tod_pkg::ACCEL_W-1] ? (tod_pkg::MAG_W'(0) - ext_y) : ext_y;
	assign th_ext = {{(tod_pkg::MAG_W - tod_pkg::TH_W){1'b0}}, tilt_th};
	assign x_pos  = !accel_x[tod_pkg::ACCEL_W-1] && (accel_x != '0);
	assign y_pos  = !accel_y[tod_pkg::ACCEL_W-1] && (accel_y != '0);

	// The dominant axis and its sign pick the rotation; ties go to the X axis.
	always_comb begin
		verdict.ambiguous = (mag_x < th_ext) && (mag_y < th_ext);
		if (mag_y > mag_x) begin
			verdict.rot = y_pos ? tod_pkg::ROT_Y_POS : tod_pkg::ROT_Y_NEG;
		end else begin
			verdict.rot = x_pos ? tod_pkg::ROT_X_POS : tod_pkg::ROT_X_NEG;
		end
	end

endmodule

// ===== hw/rtl/tod_track.sv =====
module tod_track (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [tod_pkg::TIME_W-1:0]   now_ms,
	input  logic                         sample_ok,
	input  tod_pkg::class_t              verdict,
	input  tod_pkg::cfg_t                cfg,
	output logic [1:0]                   rotation,
	output logic                         changed
);

	logic [1:0]                 current_rot_q;
	logic [1:0]                 candidate_rot_q;
	logic [tod_pkg::TIME_W-1:0] candidate_start_q;
	logic [tod_pkg::TIME_W-1:0] last_poll_q;

	logic [1:0]                 current_rot_d;
	logic [1:0]                 candidate_rot_d;
	logic [tod_pkg::TIME_W-1:0] candidate_start_d;
	logic [tod_pkg::TIME_W-1:0] last_poll_d;

	logic [tod_pkg::TIME_W-1:0] poll_age;
	logic [tod_pkg::TIME_W-1:0] cand_age;
	logic                       poll_due;
	logic                       cand_held;

	// Elapsed times wrap with the free-running clock.
	assign poll_age  = now_ms - last_poll_q;
	assign cand_age  = now_ms - candidate_start_q;
	assign poll_due  = poll_age >= {{(tod_pkg::TIME_W - 16){1'b0}}, cfg.poll_ms};
	assign cand_held = cand_age >= {{(tod_pkg::TIME_W - 16){1'b0}}, cfg.stable_ms};

	// Debounce decision for the item that leaves the input stage this cycle.
	always_comb begin
		current_rot_d     = current_rot_q;
		candidate_rot_d   = candidate_rot_q;
		candidate_start_d = candidate_start_q;
		last_poll_d       = last_poll_q;
		changed           = 1'b0;
		if (cfg.enabled && poll_due) begin
			last_poll_d = now_ms;
			if (sample_ok) begin
				if (verdict.ambiguous || (verdict.rot == current_rot_q)) begin
					candidate_rot_d = current_rot_q;
				end else if (verdict.rot != candidate_rot_q) begin
					candidate_rot_d   = verdict.rot;
					candidate_start_d = now_ms;
				end else if (cand_held) begin
					current_rot_d = verdict.rot;
					changed       = 1'b1;
				end
			end
		end
		rotation = current_rot_d;
	end

	// Tracker state moves only when an item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_rot_q     <= '0;
			candidate_rot_q   <= '0;
			candidate_start_q <= '0;
			last_poll_q       <= '0;
		end else if (step) begin
			current_rot_q     <= current_rot_d;
			candidate_rot_q   <= candidate_rot_d;
			candidate_start_q <= candidate_start_d;
			last_poll_q       <= last_poll_d;
		end
	end

endmodule

// ===== hw/rtl/tilt_orientation_debouncer.sv =====
// An item passes the input register, then the result register. Throughput: one item per cycle
// while the output is not stalled; the tracker state updates as an item moves from the input
// register to the result register, so each item sees the state left by the one before.
// Reset (arst_n low, asynchronous): rotation state, poll and candidate times clear to zero,
// configuration returns to disabled, 100 ms poll, 300 ms stable time, threshold 4096.
module tilt_orientation_debouncer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tod_pkg::TIME_W-1:0]          now_ms,
	input  logic signed [tod_pkg::ACCEL_W-1:0]  accel_x,
	input  logic signed [tod_pkg::ACCEL_W-1:0]  accel_y,
	input  logic                                sample_ok,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          rotation,
	output logic                                changed,
	input  logic                                cfg_we,
	input  tod_pkg::cfg_idx_t                   cfg_index,
	input  logic [tod_pkg::CFG_DATA_W-1:0]      cfg_data
);

	tod_pkg::cfg_t cfg_q;

	logic                              valid_s1;
	logic [tod_pkg::TIME_W-1:0]        now_s1;
	logic signed [tod_pkg::ACCEL_W-1:0] accel_x_s1;
	logic signed [tod_pkg::ACCEL_W-1:0] accel_y_s1;
	logic                              ok_s1;

	logic            out_valid_q;
	logic [1:0]      rotation_q;
	logic            changed_q;

	tod_pkg::class_t verdict;
	logic [1:0]      rot_next;
	logic            changed_next;
	logic            advance;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled   <= 1'b0;
			cfg_q.poll_ms   <= tod_pkg::POLL_MS_RST;
			cfg_q.stable_ms <= tod_pkg::STABLE_MS_RST;
			cfg_q.tilt_th   <= tod_pkg::TILT_TH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tod_pkg::CFG_ENABLED:   cfg_q.enabled   <= cfg_data[0];
				tod_pkg::CFG_POLL_MS:   cfg_q.poll_ms   <= cfg_data;
				tod_pkg::CFG_STABLE_MS: cfg_q.stable_ms <= cfg_data;
				tod_pkg::CFG_TILT_TH:   cfg_q.tilt_th   <= cfg_data[tod_pkg::TH_W-1:0];
				default: ;
			endcase
		end
	end

	// The input stage moves on when the result register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			now_s1     <= now_ms;
			accel_x_s1 <= accel_x;
			accel_y_s1 <= accel_y;
			ok_s1      <= sample_ok;
		end
	end

	tod_classify u_classify (
		.accel_x (accel_x_s1),
		.accel_y (accel_y_s1),
		.tilt_th (cfg_q.tilt_th),
		.verdict (verdict)
	);

	tod_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.now_ms    (now_s1),
		.sample_ok (ok_s1),
		.verdict   (verdict),
		.cfg       (cfg_q),
		.rotation  (rot_next),
		.changed   (changed_next)
	);

	// Result register; it holds its transfer while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rotation_q <= rot_next;
			changed_q  <= changed_next;
		end
	end

	assign out_valid = out_valid_q;
	assign rotation  = rotation_q;
	assign changed   = changed_q;

endmodule
